// ----- rtl/nearest_palette_color_ccir_defines.svh -----
// Assertion macros shared by npc_dist and the top level.
`ifndef NEAREST_PALETTE_COLOR_CCIR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_CCIR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NPC_ASSERT_IMPL(label, ante, cons)
`define NPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/npc_pkg.sv -----
// Types, constants and control store of the nearest palette colour search.
package npc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
  localparam int DIST_W          = 39;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic CFG_COLOR_COUNT = 1'b0;
  localparam logic CFG_TRANSPARENT = 1'b1;

  localparam logic [8:0] COLOR_COUNT_RST = 9'd256;

  typedef struct packed {
    logic       operation;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       entry_used;
  } in_t;

  typedef struct packed {
    logic [7:0] best_index;
    logic       any_eligible;
  } out_t;

  typedef struct packed {
    logic start;
    logic op_write;
    logic scan_more;
    logic pipe_busy;
  } seq_cond_t;

  typedef struct packed {
    logic busy;
    logic clr;
    logic issue;
    logic emit;
    logic mem_we;
  } ctrl_t;

  localparam logic [2:0] STEP_IDLE     = 3'd0;
  localparam logic [2:0] STEP_DISPATCH = 3'd1;
  localparam logic [2:0] STEP_SCAN     = 3'd2;
  localparam logic [2:0] STEP_DRAIN    = 3'd3;
  localparam logic [2:0] STEP_EMIT     = 3'd4;
  localparam logic [2:0] STEP_WRITE    = 3'd5;

  localparam logic [2:0] U_NEXT         = 3'd0;
  localparam logic [2:0] U_JMP          = 3'd1;
  localparam logic [2:0] U_IF_NOT_START = 3'd2;
  localparam logic [2:0] U_IF_WRITE     = 3'd3;
  localparam logic [2:0] U_IF_SCAN_MORE = 3'd4;
  localparam logic [2:0] U_IF_PIPE_BUSY = 3'd5;

  typedef struct packed {
    logic [2:0] cond;
    logic [2:0] target;
    ctrl_t      ctrl;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [2:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.cond = U_IF_NOT_START;  w.target = STEP_IDLE;
      end
      STEP_DISPATCH: begin
        w.cond = U_IF_WRITE;      w.target = STEP_WRITE;
        w.ctrl.busy = 1'b1;       w.ctrl.clr = 1'b1;
      end
      STEP_SCAN: begin
        w.cond = U_IF_SCAN_MORE;  w.target = STEP_SCAN;
        w.ctrl.busy = 1'b1;       w.ctrl.issue = 1'b1;
      end
      STEP_DRAIN: begin
        w.cond = U_IF_PIPE_BUSY;  w.target = STEP_DRAIN;
        w.ctrl.busy = 1'b1;
      end
      STEP_EMIT: begin
        w.cond = U_JMP;           w.target = STEP_IDLE;
        w.ctrl.busy = 1'b1;       w.ctrl.emit = 1'b1;
      end
      STEP_WRITE: begin
        w.cond = U_JMP;           w.target = STEP_IDLE;
        w.ctrl.busy = 1'b1;       w.ctrl.mem_we = 1'b1;
      end
      default: begin
        w.cond = U_JMP;           w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/npc_seq.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module npc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  npc_pkg::seq_cond_t cond_i,
  output npc_pkg::ctrl_t     ctrl_o
);

  logic [2:0]      step_r;
  logic [2:0]      step_nxt;
  npc_pkg::ucode_t uw;
  logic            take;

  always_comb begin
    uw = npc_pkg::ucode_rom(step_r);
    case (uw.cond)
      npc_pkg::U_NEXT:         take = 1'b0;
      npc_pkg::U_JMP:          take = 1'b1;
      npc_pkg::U_IF_NOT_START: take = !cond_i.start;
      npc_pkg::U_IF_WRITE:     take = cond_i.op_write;
      npc_pkg::U_IF_SCAN_MORE: take = cond_i.scan_more;
      npc_pkg::U_IF_PIPE_BUSY: take = cond_i.pipe_busy;
      default:                 take = 1'b1;
    endcase
    step_nxt = take ? uw.target : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= npc_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl_o = uw.ctrl;

endmodule

// ----- rtl/npc_dist.sv -----
// Pipelined CCIR-601 weighted distance between query colour and palette entry.
`include "nearest_palette_color_ccir_defines.svh"

module npc_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [npc_pkg::PAL_IDX_W-1:0] idx_i,
  input  logic [23:0]                   entry_i,
  input  logic [23:0]                   query_i,
  output logic                          valid_o,
  output logic [npc_pkg::PAL_IDX_W-1:0] idx_o,
  output logic [npc_pkg::DIST_W-1:0]    dist_o,
  output logic                          busy_o
);

  logic                          v2_r, v3_r, v4_r, v5_r;
  logic [npc_pkg::PAL_IDX_W-1:0] i2_r, i3_r, i4_r, i5_r;

  logic signed [8:0]             dr_r, dg_r, db_r;
  logic [15:0]                   sqr_r, sqg_r, sqb_r;
  logic signed [18:0]            l_r;
  logic [25:0]                   s_r;
  logic [35:0]                   l2_r;
  logic [npc_pkg::DIST_W-1:0]    d_r;

  logic signed [8:0]             dr_nxt, dg_nxt, db_nxt;
  logic signed [17:0]            pr, pg, pb;
  logic signed [18:0]            l_nxt;
  logic [25:0]                   s_nxt;
  logic signed [37:0]            pl;
  logic [npc_pkg::DIST_W-1:0]    d_nxt;

  always_comb begin
    dr_nxt = $signed({1'b0, query_i[23:16]}) - $signed({1'b0, entry_i[23:16]});
    dg_nxt = $signed({1'b0, query_i[15:8]})  - $signed({1'b0, entry_i[15:8]});
    db_nxt = $signed({1'b0, query_i[7:0]})   - $signed({1'b0, entry_i[7:0]});
    pr     = dr_r * dr_r;
    pg     = dg_r * dg_r;
    pb     = db_r * db_r;
    l_nxt  = 19'sd299 * 19'(dr_r) + 19'sd587 * 19'(dg_r) + 19'sd114 * 19'(db_r);
    s_nxt  = 26'd299 * 26'(sqr_r) + 26'd587 * 26'(sqg_r) + 26'd114 * 26'(sqb_r);
    pl     = l_r * l_r;
    d_nxt  = 39'd3000 * 39'(s_r) + 39'({l2_r, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v2_r <= valid_i;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    i2_r  <= idx_i;
    i3_r  <= i2_r;
    i4_r  <= i3_r;
    i5_r  <= i4_r;
    dr_r  <= dr_nxt;
    dg_r  <= dg_nxt;
    db_r  <= db_nxt;
    sqr_r <= pr[15:0];
    sqg_r <= pg[15:0];
    sqb_r <= pb[15:0];
    l_r   <= l_nxt;
    s_r   <= s_nxt;
    l2_r  <= pl[35:0];
    d_r   <= d_nxt;
  end

  assign valid_o = v5_r;
  assign idx_o   = i5_r;
  assign dist_o  = d_r;
  assign busy_o  = v2_r | v3_r | v4_r | v5_r;

  `NPC_ASSERT_IMPL(a_dist_latency, v5_r, $past(valid_i, 4))

endmodule

// ----- rtl/nearest_palette_color_ccir.sv -----
// Nearest palette colour search: top level with palette store, scan and best-match tracking.
//
// A write item (operation 0) stores one palette entry and its used flag and yields no
// result. A search item (operation 1) walks entries 0 .. n-1, one per cycle, where n is
// color_count limited to the table size, through a palette read stage and a four-stage
// distance pipeline, then returns one result once the pipeline has drained, sooner when
// the last entries are skipped. The scan reads the palette memory's single read port
// once per cycle. busy stays high for the whole item. The result appears for one cycle
// on out_data with out_valid high and must be taken then. Entries marked unused and the
// transparent index are skipped; a tie keeps the lower index; with no eligible entry
// best_index is 1 and any_eligible 0. cfg_ready is always high; write configuration
// only while busy is low.
`include "nearest_palette_color_ccir_defines.svh"

module nearest_palette_color_ccir (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  npc_pkg::in_t   in_data,
  output logic           out_valid,
  output npc_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [8:0]     cfg_data
);

  localparam int IW = npc_pkg::PAL_IDX_W;
  localparam int CW = npc_pkg::CNT_W;

  npc_pkg::ctrl_t     ctrl;
  npc_pkg::seq_cond_t cond;

  npc_pkg::in_t       in_r;
  logic [8:0]         color_count_r;
  logic [7:0]         transparent_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      n_lim;
  logic [CW:0]        cnt_inc;
  logic               issue_go;
  logic               eligible;

  logic [23:0]        mem [npc_pkg::PALETTE_ENTRIES];
  logic [npc_pkg::PALETTE_ENTRIES-1:0] used_r;
  logic [23:0]        rd_r;
  logic               v1_r;
  logic [IW-1:0]      i1_r;
  logic               wr_ok;

  logic               d_valid;
  logic [IW-1:0]      d_idx;
  logic [npc_pkg::DIST_W-1:0] d_val;
  logic               dist_busy;

  logic [npc_pkg::DIST_W-1:0] best_d_r;
  logic [7:0]         best_r;
  logic               found_r;

  npc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  always_comb begin
    n_lim = (color_count_r > 9'(npc_pkg::PALETTE_ENTRIES)) ?
            CW'(npc_pkg::PALETTE_ENTRIES) : CW'(color_count_r);
    cnt_inc  = (CW + 1)'(cnt_r) + (CW + 1)'(1);
    issue_go = ctrl.issue && (cnt_r < n_lim);
    eligible = used_r[cnt_r[IW-1:0]] && (9'(cnt_r) != {1'b0, transparent_r});
    wr_ok    = {1'b0, in_r.entry_index} < 9'(npc_pkg::PALETTE_ENTRIES);

    cond.start     = start;
    cond.op_write  = (in_r.operation == npc_pkg::OP_WRITE);
    cond.scan_more = cnt_inc < (CW + 1)'(n_lim);
    cond.pipe_busy = v1_r | dist_busy;
  end

  always_ff @(posedge clk) begin
    if (start && !ctrl.busy) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= npc_pkg::COLOR_COUNT_RST;
      transparent_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        npc_pkg::CFG_COLOR_COUNT: color_count_r <= cfg_data;
        npc_pkg::CFG_TRANSPARENT: transparent_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_we && wr_ok) begin
      mem[in_r.entry_index[IW-1:0]] <= {in_r.red, in_r.green, in_r.blue};
    end
    rd_r <= mem[cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctrl.mem_we && wr_ok) begin
      used_r[in_r.entry_index[IW-1:0]] <= in_r.entry_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
    end else begin
      if (ctrl.clr) begin
        cnt_r <= '0;
      end else if (ctrl.issue) begin
        cnt_r <= cnt_inc[CW-1:0];
      end
      v1_r <= issue_go && eligible;
    end
  end

  always_ff @(posedge clk) begin
    i1_r <= cnt_r[IW-1:0];
  end

  npc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v1_r),
    .idx_i   (i1_r),
    .entry_i (rd_r),
    .query_i ({in_r.red, in_r.green, in_r.blue}),
    .valid_o (d_valid),
    .idx_o   (d_idx),
    .dist_o  (d_val),
    .busy_o  (dist_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      best_r  <= 8'd1;
    end else if (ctrl.clr) begin
      found_r <= 1'b0;
      best_r  <= 8'd1;
    end else if (d_valid && (!found_r || d_val < best_d_r)) begin
      found_r <= 1'b1;
      best_r  <= 8'(d_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && (!found_r || d_val < best_d_r)) begin
      best_d_r <= d_val;
    end
  end

  assign busy                  = ctrl.busy;
  assign out_valid             = ctrl.emit;
  assign out_data.best_index   = best_r;
  assign out_data.any_eligible = found_r;
  assign cfg_ready             = 1'b1;

  `NPC_ASSERT_IMPL(a_emit_drained, out_valid, !v1_r && !dist_busy)
  `NPC_ASSERT_IMPL(a_none_index_one, out_valid && !found_r, best_r == 8'd1)
  `NPC_ASSERT_NEXT(a_write_silent, start && !busy && in_data.operation == npc_pkg::OP_WRITE,
                   !out_valid)

endmodule

// ----- dv/tb_nearest_palette_color_ccir.sv -----
// Self-checking testbench for the nearest palette colour search block.
`timescale 1ns / 1ps

module tb_nearest_palette_color_ccir;

  localparam int LIMIT_CYCLES    = 1500000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int N_PHASES        = 6;
  localparam int N_DIRECTED      = 20;

  typedef struct packed {
    npc_pkg::in_t  item;
    logic          typed;
    npc_pkg::out_t res;
  } stim_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  npc_pkg::in_t  in_data;
  logic          out_valid;
  npc_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_index;
  logic [8:0]    cfg_data;

  logic [23:0]   pal_rgb [npc_pkg::PALETTE_ENTRIES];
  bit            pal_used [npc_pkg::PALETTE_ENTRIES];
  logic [8:0]    pal_count;
  logic [7:0]    pal_transp;
  npc_pkg::out_t nearest_q[$];
  int            errors;
  int            cycles;
  stim_row_t     dir_rows [N_DIRECTED];

  int unsigned count_set  [N_PHASES] = '{256, 511, 0, 2, 17, 0};
  int unsigned transp_set [N_PHASES] = '{0, 255, 3, 1, 0, 0};
  int unsigned idle_pct   [N_PHASES] = '{0, 57, 34, 0, 57, 34};

  nearest_palette_color_ccir u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic npc_pkg::out_t nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
    npc_pkg::out_t res;
    longint        dr, dg, db, s, l, d, best_d;
    int            lim;
    bit            found;
    res.best_index   = 8'd1;
    res.any_eligible = 1'b0;
    found  = 1'b0;
    best_d = 0;
    lim    = (pal_count > npc_pkg::PALETTE_ENTRIES) ? npc_pkg::PALETTE_ENTRIES
                                                     : int'(pal_count);
    for (int i = 0; i < lim; i++) begin
      if (i == int'(pal_transp) || !pal_used[i]) continue;
      dr = longint'(r) - longint'(pal_rgb[i][23:16]);
      dg = longint'(g) - longint'(pal_rgb[i][15:8]);
      db = longint'(b) - longint'(pal_rgb[i][7:0]);
      s  = 299 * dr * dr + 587 * dg * dg + 114 * db * db;
      l  = 299 * dr + 587 * dg + 114 * db;
      d  = 3000 * s + 4 * l * l;
      if (!found || d < best_d) begin
        found            = 1'b1;
        best_d           = d;
        res.best_index   = 8'(i);
        res.any_eligible = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic stim_row_t mk(input logic op, input int idx, input int r, input int g,
                                   input int b, input logic used, input logic typed,
                                   input int bi, input logic ae);
    stim_row_t row;
    row.item.operation    = op;
    row.item.entry_index  = 8'(idx);
    row.item.red          = 8'(r);
    row.item.green        = 8'(g);
    row.item.blue         = 8'(b);
    row.item.entry_used   = used;
    row.typed             = typed;
    row.res.best_index    = 8'(bi);
    row.res.any_eligible  = ae;
    return row;
  endfunction

  function automatic logic [7:0] rand_comp();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic npc_pkg::in_t random_item();
    npc_pkg::in_t it;
    logic [7:0]   near_idx;
    int           pick;
    it.operation   = ($urandom_range(99) < 50) ? npc_pkg::OP_SEARCH : npc_pkg::OP_WRITE;
    near_idx       = ($urandom_range(9) < 6) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
    it.entry_index = near_idx;
    it.entry_used  = ($urandom_range(9) < 8);
    pick           = $urandom_range(9);
    if (pick < 3 && it.operation == npc_pkg::OP_SEARCH) begin
      {it.red, it.green, it.blue} = pal_rgb[near_idx];
    end else if (pick < 3) begin
      // a few shared shades so that ties between entries occur
      case ($urandom_range(3))
        0:       {it.red, it.green, it.blue} = 24'h000000;
        1:       {it.red, it.green, it.blue} = 24'hFFFFFF;
        2:       {it.red, it.green, it.blue} = 24'h808080;
        default: {it.red, it.green, it.blue} = 24'h10E020;
      endcase
    end else begin
      it.red   = rand_comp();
      it.green = rand_comp();
      it.blue  = rand_comp();
    end
    return it;
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input npc_pkg::in_t it, input logic typed, input npc_pkg::out_t res);
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.operation == npc_pkg::OP_WRITE) begin
      pal_rgb[it.entry_index]  = {it.red, it.green, it.blue};
      pal_used[it.entry_index] = it.entry_used;
    end else begin
      nearest_q.insert(nearest_q.size(),
                       typed ? res : nearest_entry(it.red, it.green, it.blue));
    end
    @(negedge clk);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input int unsigned cnt, input int unsigned tr);
    cfg_valid <= 1'b1;
    cfg_index <= npc_pkg::CFG_COLOR_COUNT;
    cfg_data  <= 9'(cnt);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pal_count = 9'(cnt);
    @(negedge clk);
    cfg_index <= npc_pkg::CFG_TRANSPARENT;
    cfg_data  <= {1'b0, 8'(tr)};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pal_transp = 8'(tr);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    npc_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (nearest_q.size() == 0) begin
        $display("%0t: result with none expected, actual best_index %0d any_eligible %0b",
                 $time, out_data.best_index, out_data.any_eligible);
        errors++;
      end else begin
        want = nearest_q.pop_front();
        if (out_data.best_index !== want.best_index) begin
          $display("%0t: best_index mismatch, expected %0d actual %0d",
                   $time, want.best_index, out_data.best_index);
          errors++;
        end
        if (out_data.any_eligible !== want.any_eligible) begin
          $display("%0t: any_eligible mismatch, expected %0b actual %0b",
                   $time, want.any_eligible, out_data.any_eligible);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned cnt, tr, pct;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = npc_pkg::CFG_COLOR_COUNT;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    pal_count  = npc_pkg::COLOR_COUNT_RST;
    pal_transp = 8'd0;
    for (int i = 0; i < npc_pkg::PALETTE_ENTRIES; i++) begin
      pal_rgb[i]  = '0;
      pal_used[i] = 1'b0;
    end

    dir_rows[0]  = mk(npc_pkg::OP_SEARCH,   0,   0,   0,   0, 1'b0, 1'b1,   1, 1'b0);
    dir_rows[1]  = mk(npc_pkg::OP_WRITE,    0, 255, 255, 255, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[2]  = mk(npc_pkg::OP_SEARCH,   0, 255, 255, 255, 1'b0, 1'b1,   1, 1'b0);
    dir_rows[3]  = mk(npc_pkg::OP_WRITE,  255,   0,   0,   0, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[4]  = mk(npc_pkg::OP_WRITE,    1, 255,   0,   0, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[5]  = mk(npc_pkg::OP_SEARCH,   0,   0,   0,   0, 1'b0, 1'b1, 255, 1'b1);
    dir_rows[6]  = mk(npc_pkg::OP_SEARCH,   0, 255,   0,   0, 1'b0, 1'b1,   1, 1'b1);
    dir_rows[7]  = mk(npc_pkg::OP_WRITE,    2, 255,   0,   0, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[8]  = mk(npc_pkg::OP_SEARCH,   0, 250,   5,   5, 1'b0, 1'b1,   1, 1'b1);
    dir_rows[9]  = mk(npc_pkg::OP_WRITE,    1, 255,   0,   0, 1'b0, 1'b0,   0, 1'b0);
    dir_rows[10] = mk(npc_pkg::OP_SEARCH,   0, 250,   5,   5, 1'b0, 1'b1,   2, 1'b1);
    dir_rows[11] = mk(npc_pkg::OP_WRITE,  128,   0, 255,   0, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[12] = mk(npc_pkg::OP_WRITE,   64,   0,   0, 255, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[13] = mk(npc_pkg::OP_SEARCH,   0,   0,   0, 255, 1'b0, 1'b1,  64, 1'b1);
    dir_rows[14] = mk(npc_pkg::OP_SEARCH,   0,   0, 255,   0, 1'b0, 1'b1, 128, 1'b1);
    dir_rows[15] = mk(npc_pkg::OP_SEARCH,   0, 128, 128, 128, 1'b0, 1'b0,   0, 1'b0);
    dir_rows[16] = mk(npc_pkg::OP_WRITE,  170, 170,  85, 170, 1'b1, 1'b0,   0, 1'b0);
    dir_rows[17] = mk(npc_pkg::OP_WRITE,   85,  85, 170,  85, 1'b0, 1'b0,   0, 1'b0);
    dir_rows[18] = mk(npc_pkg::OP_SEARCH,   0, 170,  85, 170, 1'b0, 1'b1, 170, 1'b1);
    dir_rows[19] = mk(npc_pkg::OP_SEARCH,   0,  85, 170,  85, 1'b0, 1'b0,   0, 1'b0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      quiesce();
      cnt = (p == N_PHASES - 1) ? $urandom_range(511) : count_set[p];
      tr  = (p == N_PHASES - 1) ? $urandom_range(255) : transp_set[p];
      pct = idle_pct[p];
      apply_settings(cnt, tr);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 1 && k == ITEMS_PER_PHASE / 2) begin
          // hold off until every outstanding search has returned
          start <= 1'b0;
          do @(negedge clk); while (nearest_q.size() != 0);
        end else if ($urandom_range(99) < pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 300 : 30)) @(negedge clk);
        end
        send_item(random_item(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
